@@ rtl/fcpr_pkg.sv @@
// Shared types, constants and reply-frame tables for the framed command parser.
package fcpr_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_7     = 8'h37;

  localparam logic [7:0] CMD_ALIVE    = 8'hF0;
  localparam logic [7:0] CMD_ACK      = 8'h0D;
  localparam logic [7:0] CMD_FIRMWARE = 8'hF1;
  localparam logic [7:0] CMD_UNKNOWN  = 8'hFF;

  localparam logic [7:0] LEN_LONG  = 8'h05;
  localparam logic [7:0] LEN_SHORT = 8'h04;

  localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R;
  localparam logic [7:0] PFX_XOR = HDR_XOR ^ CH_COLON ^ CH_9 ^ CH_7;

  localparam logic [7:0] CS_ALIVE    = PFX_XOR ^ LEN_LONG ^ CMD_ALIVE ^ CMD_ACK;
  localparam logic [7:0] CS_FIRMWARE = PFX_XOR ^ LEN_SHORT ^ CMD_FIRMWARE;
  localparam logic [7:0] CS_UNKNOWN  = PFX_XOR ^ LEN_SHORT ^ CMD_UNKNOWN;

  localparam logic [3:0] FRAME_LEN_LONG  = 4'd11;
  localparam logic [3:0] FRAME_LEN_SHORT = 4'd10;

  typedef enum logic [1:0] {
    RPL_ALIVE    = 2'd0,
    RPL_FIRMWARE = 2'd1,
    RPL_UNKNOWN  = 2'd2
  } reply_kind_t;

  typedef struct packed {
    logic        valid;
    reply_kind_t kind;
  } reply_req_t;

  function automatic reply_kind_t classify(logic [7:0] code);
    reply_kind_t k;
    k = RPL_UNKNOWN;
    if (code == CMD_ALIVE) k = RPL_ALIVE;
    else if (code == CMD_FIRMWARE) k = RPL_FIRMWARE;
    return k;
  endfunction

  function automatic logic [3:0] reply_len(reply_kind_t kind);
    return (kind == RPL_ALIVE) ? FRAME_LEN_LONG : FRAME_LEN_SHORT;
  endfunction

  function automatic logic [7:0] reply_byte(reply_kind_t kind, logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0: b = CH_U;
      4'd1: b = CH_N;
      4'd2: b = CH_E;
      4'd3: b = CH_R;
      4'd4: b = (kind == RPL_ALIVE) ? LEN_LONG : LEN_SHORT;
      4'd5: b = CH_COLON;
      4'd6: b = CH_9;
      4'd7: b = CH_7;
      4'd8: begin
        case (kind)
          RPL_ALIVE:    b = CMD_ALIVE;
          RPL_FIRMWARE: b = CMD_FIRMWARE;
          default:      b = CMD_UNKNOWN;
        endcase
      end
      4'd9: begin
        case (kind)
          RPL_ALIVE:    b = CMD_ACK;
          RPL_FIRMWARE: b = CS_FIRMWARE;
          default:      b = CS_UNKNOWN;
        endcase
      end
      4'd10: b = CS_ALIVE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/fcpr_if.sv @@
// Valid/ready channel interfaces for received bytes and reply bytes.
interface fcpr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface fcpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output tx_byte, output last, input ready);
  modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

@@ rtl/framed_command_parser_responder.sv @@
// Top level of the framed command parser and responder.
// Takes one received byte (or one unsolicited-alive request) per cycle and
// answers each good frame with a 10- or 11-byte reply frame, sent one byte
// per cycle while the result channel is ready, with last set on the checksum
// byte. The input side takes one transaction per cycle while the reply queue
// has room; the output side, a single byte emitter with one output register,
// sets the sustained limit of one reply byte per cycle, so a stream of minimal
// frames that all draw replies (seven bytes in, ten out) is output-bound.
// Up to QUEUE_DEPTH replies wait between parser and emitter.
module framed_command_parser_responder #(
  parameter int QUEUE_DEPTH = fcpr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  fcpr_in_if.sink     in_ch,
  fcpr_out_if.source  out_ch
);

  fcpr_pkg::reply_req_t push;
  fcpr_pkg::reply_req_t head;
  logic                 q_full;
  logic                 pop;

  fcpr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  fcpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  fcpr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/fcpr_front.sv @@
// Front end: frame parser; queues replies for good frames and alive requests.
module fcpr_front (
  input  logic                clk,
  input  logic                rst_n,
  fcpr_in_if.sink             in_ch,
  input  logic                q_full,
  output fcpr_pkg::reply_req_t push
);

  typedef enum logic [6:0] {
    PS_HUNT    = 7'b0000001,
    PS_HDR1    = 7'b0000010,
    PS_HDR2    = 7'b0000100,
    PS_HDR3    = 7'b0001000,
    PS_LEN     = 7'b0010000,
    PS_TOKEN   = 7'b0100000,
    PS_PAYLOAD = 7'b1000000
  } parse_state_t;

  parse_state_t          state_r, state_nxt;
  logic [7:0]            rem_r, rem_nxt;
  logic [7:0]            csum_r, csum_nxt;
  logic [1:0]            off_r, off_nxt;
  fcpr_pkg::reply_kind_t kind_r, kind_nxt;
  logic                  accept;
  logic [7:0]            b;
  logic [7:0]            eff;
  parse_state_t          hunt_state;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign eff         = (rem_r == 8'd0) ? 8'hFF : rem_r;
  assign hunt_state  = (b == fcpr_pkg::CH_U) ? PS_HDR1 : PS_HUNT;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    csum_nxt  = csum_r;
    off_nxt   = off_r;
    kind_nxt  = kind_r;
    push      = '{valid: 1'b0, kind: fcpr_pkg::RPL_ALIVE};
    if (accept) begin
      if (in_ch.mode) begin
        push = '{valid: 1'b1, kind: fcpr_pkg::RPL_ALIVE};
      end else begin
        case (state_r)
          PS_HUNT: state_nxt = hunt_state;
          PS_HDR1: state_nxt = (b == fcpr_pkg::CH_N) ? PS_HDR2 : hunt_state;
          PS_HDR2: state_nxt = (b == fcpr_pkg::CH_E) ? PS_HDR3 : hunt_state;
          PS_HDR3: state_nxt = (b == fcpr_pkg::CH_R) ? PS_LEN : hunt_state;
          PS_LEN: begin
            rem_nxt   = b;
            state_nxt = PS_TOKEN;
          end
          PS_TOKEN: begin
            if (b == fcpr_pkg::CH_COLON) begin
              state_nxt = PS_PAYLOAD;
              csum_nxt  = fcpr_pkg::HDR_XOR ^ fcpr_pkg::CH_COLON ^ rem_r;
              off_nxt   = 2'd0;
              kind_nxt  = fcpr_pkg::RPL_UNKNOWN;
            end else begin
              state_nxt = hunt_state;
            end
          end
          PS_PAYLOAD: begin
            if (eff > 8'd1) begin
              csum_nxt = csum_r ^ b;
              if (off_r == 2'd2) kind_nxt = fcpr_pkg::classify(b);
              if (off_r != 2'd3) off_nxt = off_r + 2'd1;
              rem_nxt = eff - 8'd1;
            end else begin
              rem_nxt   = 8'd0;
              state_nxt = hunt_state;
              if (csum_r == b) push = '{valid: 1'b1, kind: kind_r};
            end
          end
          default: state_nxt = hunt_state;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_HUNT;
      rem_r   <= 8'd0;
      csum_r  <= 8'd0;
      off_r   <= 2'd0;
      kind_r  <= fcpr_pkg::RPL_UNKNOWN;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      csum_r  <= csum_nxt;
      off_r   <= off_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

@@ rtl/fcpr_queue.sv @@
// Reply queue between the parser and the reply emitter.
module fcpr_queue #(
  parameter int DEPTH = fcpr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcpr_pkg::reply_req_t push,
  input  logic                 pop,
  output logic                 full,
  output fcpr_pkg::reply_req_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fcpr_pkg::reply_kind_t mem_r [DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count_r != '0);
  assign head    = '{valid: (count_r != '0), kind: mem_r[rd_ptr_r]};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/fcpr_back.sv @@
// Back end: emits the queued reply frames one byte per transaction.
module fcpr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcpr_pkg::reply_req_t head,
  output logic                 pop,
  fcpr_out_if.source           out_ch
);

  logic [3:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       is_last;

  assign load    = head.valid && (!valid_r || out_ch.ready);
  assign is_last = (idx_r == fcpr_pkg::reply_len(head.kind) - 4'd1);
  assign pop     = load && is_last;

  assign out_ch.valid   = valid_r;
  assign out_ch.tx_byte = byte_r;
  assign out_ch.last    = last_r;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = fcpr_pkg::reply_byte(head.kind, idx_r);
      last_nxt  = is_last;
      idx_nxt   = is_last ? 4'd0 : idx_r + 4'd1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

@@ rtl/fcpr_checker.sv @@
// Port-level checker for the framed command parser, bound to the top level.
module fcpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result channel valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tx_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_last_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      out_tx_byte == fcpr_pkg::CS_ALIVE || out_tx_byte == fcpr_pkg::CS_FIRMWARE ||
      out_tx_byte == fcpr_pkg::CS_UNKNOWN)
    else $error("final reply byte is not a valid reply checksum");

endmodule

bind framed_command_parser_responder fcpr_checker u_fcpr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_tx_byte (out_ch.tx_byte),
  .out_last    (out_ch.last)
);
